// ===== rtl/core/rzse_pkg.sv =====
// Shared widths, codes and defaults for the rolling z-score signal engine.
// No dependencies; imported by rolling_zscore_signal_engine.
package rzse_pkg;

    localparam int PRICE_W = 24;
    localparam int MID_W   = PRICE_W + 1;
    localparam int QTY_W   = 32;
    localparam int POS_W   = 32;
    localparam int SYM_IDX_W = 2;

    localparam int DEFAULT_WINDOW  = 64;
    localparam int DEFAULT_SYMBOLS = 4;

    typedef enum logic
    {
        ACT_TICK = 1'b0,
        ACT_FILL = 1'b1
    } action_t;

    typedef enum logic
    {
        SIDE_BUY  = 1'b0,
        SIDE_SELL = 1'b1
    } side_t;

endpackage

// ===== rtl/core/rolling_zscore_signal_engine.sv =====
// Top level of the rolling z-score mean-reversion signal engine.
// Depends on rzse_pkg and rzse_ram.
//
// The engine takes one transfer per clock on the input channel and gives at most one order
// per tick on the output channel. Each tracked symbol keeps a ring of its last WINDOW mid
// values (bid + ask, in half ticks) in a shared ring RAM, plus an exact running sum S and
// sum of squares Q. A tick replaces the oldest ring entry; once WINDOW ticks have arrived
// for the symbol, a flat symbol opens with quantity 1 when (W*m - S)^2 >= 4*(W*Q - S^2)
// (sell at the bid when W*m > S, else buy at the ask), and a symbol with a position closes
// it out when 4*(W*m - S)^2 <= W*Q - S^2. A fill report moves the position by its
// quantity, saturating at the signed 32-bit range. Items for a symbol index at or above
// SYMBOLS are taken and dropped. Rate: one item per clock while the pipeline has room; a
// tick passes through stages 1 to 4, and its order then through the output register. The
// rate is set by the ring RAM, which is read once at the transfer and written once, as the
// tick leaves stage 1, for every tick. The pipeline has four stages plus the output register;
// each stage moves on when the one after it is empty or moving, so input transfers go on
// while an order waits to be taken, until the stages fill. The ring needs no clearing
// pass: an entry is read as zero until the symbol's tick count says it has been written.
module rolling_zscore_signal_engine #(
    parameter int WINDOW  = rzse_pkg::DEFAULT_WINDOW,
    parameter int SYMBOLS = rzse_pkg::DEFAULT_SYMBOLS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            action,
    input  logic [rzse_pkg::SYM_IDX_W-1:0]  symbol_index,
    input  logic [rzse_pkg::PRICE_W-1:0]    bid_price,
    input  logic [rzse_pkg::PRICE_W-1:0]    ask_price,
    input  logic                            fill_side,
    input  logic [rzse_pkg::QTY_W-1:0]      fill_amount,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            order_side,
    output logic [rzse_pkg::SYM_IDX_W-1:0]  order_symbol,
    output logic [rzse_pkg::PRICE_W-1:0]    order_price,
    output logic [rzse_pkg::QTY_W-1:0]      order_qty
);

    import rzse_pkg::*;

    // Derived widths: ring slot, tick counter, running sums and products.
    localparam int HEAD_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SYM_W  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int SUM_W  = MID_W + HEAD_W;
    localparam int SQ_W   = 2 * MID_W + HEAD_W;
    localparam int PROD_W = 2 * SUM_W;
    localparam int RAM_DEPTH = SYMBOLS * (1 << HEAD_W);
    localparam int ADDR_W = $clog2(RAM_DEPTH);

    localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW);
    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(WINDOW - 1);

    // One item as it travels down the pipeline.
    typedef struct packed {
        logic                 action;
        logic [SYM_IDX_W-1:0] sym;
        logic [PRICE_W-1:0]   bid;
        logic [PRICE_W-1:0]   ask;
        logic                 side;
        logic [QTY_W-1:0]     qty;
        logic                 decide;   // tick completes the window: may give an order
        logic                 full;     // ring slot holds a real sample
    } item_t;

    // ------------------------------------------------------------------
    // Handshake and stage advance
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic out_valid_reg;
    logic out_free, go1, go2, go3, go4, fire4;
    logic accept, in_range, keep;

    assign out_free = !out_valid_reg || out_ready;
    assign go4 = !v4_reg || out_free;
    assign go3 = !v3_reg || go4;
    assign go2 = !v2_reg || go3;
    assign go1 = !v1_reg || go2;
    assign fire4 = v4_reg && out_free;

    assign in_ready = go1;
    assign accept   = in_valid && in_ready;
    assign in_range = int'(symbol_index) < SYMBOLS;
    assign keep     = accept && in_range;

    // ------------------------------------------------------------------
    // Accept: ring head and tick count, ring read
    // ------------------------------------------------------------------
    logic [HEAD_W-1:0] head_reg [SYMBOLS];
    logic [CNT_W-1:0]  cnt_reg  [SYMBOLS];
    logic [SYM_W-1:0]  in_sel;
    logic [HEAD_W-1:0] head_cur, head_next;
    logic [CNT_W-1:0]  cnt_cur, cnt_next;
    logic              in_tick, in_full, in_decide;
    logic [MID_W-1:0]  in_mid;
    item_t             in_item;

    assign in_sel    = SYM_W'(symbol_index);
    assign head_cur  = head_reg[in_sel];
    assign cnt_cur   = cnt_reg[in_sel];
    assign head_next = (head_cur == HEAD_LAST) ? '0 : head_cur + 1'b1;
    assign in_full   = (cnt_cur == CNT_FULL);
    assign cnt_next  = in_full ? cnt_cur : cnt_cur + 1'b1;
    assign in_decide = in_full || (cnt_cur == CNT_LAST);
    assign in_tick   = (action == ACT_TICK);
    assign in_mid    = {1'b0, bid_price} + {1'b0, ask_price};

    always_comb
    begin
        in_item.action = action;
        in_item.sym    = symbol_index;
        in_item.bid    = bid_price;
        in_item.ask    = ask_price;
        in_item.side   = fill_side;
        in_item.qty    = fill_amount;
        in_item.decide = in_decide;
        in_item.full   = in_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SYMBOLS; i++)
            begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else if (keep && in_tick)
        begin
            head_reg[in_sel] <= head_next;
            cnt_reg[in_sel]  <= cnt_next;
        end
    end

    // Ring RAM: read the slot to replace at the transfer, write the new mid one stage later.
    logic              ram_re, ram_we;
    logic [ADDR_W-1:0] ram_raddr, ram_waddr;
    logic [MID_W-1:0]  ram_rdata;
    logic [ADDR_W-1:0] addr1_reg;
    logic [MID_W-1:0]  m1_reg;

    assign ram_re    = keep && in_tick;
    assign ram_raddr = ADDR_W'({in_sel, head_cur});

    rzse_ram #(
        .WIDTH (MID_W),
        .DEPTH (RAM_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (m1_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: old sample, squares
    // ------------------------------------------------------------------
    item_t              it1_reg;
    logic [MID_W-1:0]   old1;
    logic [2*MID_W-1:0] mm1, oo1;

    assign ram_we    = v1_reg && go2 && (it1_reg.action == ACT_TICK);
    assign ram_waddr = addr1_reg;
    assign old1      = it1_reg.full ? ram_rdata : '0;
    assign mm1       = (2*MID_W)'(m1_reg) * (2*MID_W)'(m1_reg);
    assign oo1       = (2*MID_W)'(old1) * (2*MID_W)'(old1);

    // ------------------------------------------------------------------
    // Stage 2: running sums, read-modify-write in this stage only
    // ------------------------------------------------------------------
    item_t              it2_reg;
    logic [MID_W-1:0]   m2_reg, old2_reg;
    logic [2*MID_W-1:0] mm2_reg, oo2_reg;
    logic [SUM_W-1:0]   sum_reg [SYMBOLS];
    logic [SQ_W-1:0]    sq_reg  [SYMBOLS];
    logic [SYM_W-1:0]   sel2;
    logic [SUM_W:0]     sum_wide;
    logic [SQ_W:0]      sq_wide;
    logic [SUM_W-1:0]   sum_next, wm2;
    logic [SQ_W-1:0]    sq_next;

    assign sel2     = SYM_W'(it2_reg.sym);
    assign sum_wide = {1'b0, sum_reg[sel2]} + (SUM_W+1)'(m2_reg) - (SUM_W+1)'(old2_reg);
    assign sq_wide  = {1'b0, sq_reg[sel2]} + (SQ_W+1)'(mm2_reg) - (SQ_W+1)'(oo2_reg);
    assign sum_next = sum_wide[SUM_W-1:0];
    assign sq_next  = sq_wide[SQ_W-1:0];
    assign wm2      = SUM_W'(m2_reg) * SUM_W'(WINDOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SYMBOLS; i++)
            begin
                sum_reg[i] <= '0;
                sq_reg[i]  <= '0;
            end
        end
        else if (v2_reg && go3 && (it2_reg.action == ACT_TICK))
        begin
            sum_reg[sel2] <= sum_next;
            sq_reg[sel2]  <= sq_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: deviation and the three products
    // ------------------------------------------------------------------
    item_t             it3_reg;
    logic [SUM_W-1:0]  s3_reg, wm3_reg, dev3;
    logic [SQ_W-1:0]   q3_reg;
    logic [PROD_W-1:0] dev2_3, s2_3, wq_3;
    logic              dir3;

    assign dir3   = wm3_reg > s3_reg;
    assign dev3   = (wm3_reg >= s3_reg) ? wm3_reg - s3_reg : s3_reg - wm3_reg;
    assign dev2_3 = PROD_W'(dev3) * PROD_W'(dev3);
    assign s2_3   = PROD_W'(s3_reg) * PROD_W'(s3_reg);
    assign wq_3   = PROD_W'(q3_reg) * PROD_W'(WINDOW);

    // ------------------------------------------------------------------
    // Stage 4: thresholds, position read-modify-write, order
    // ------------------------------------------------------------------
    item_t             it4_reg;
    logic [PROD_W-1:0] dev2_4_reg, s2_4_reg, wq_4_reg;
    logic              dir4_reg;
    logic              open_ok, close_ok, flat, hit4;
    logic [POS_W-1:0]  pos_reg [SYMBOLS];
    logic [SYM_W-1:0]  sel4;
    logic [POS_W-1:0]  pos_cur, pos_abs, pos_next;
    logic signed [POS_W+1:0] pos_ext, qty_ext, fill_sum;
    logic [2:0]        fill_top;

    assign open_ok  = ({3'b000, dev2_4_reg} + {1'b0, s2_4_reg, 2'b00})
                      >= {1'b0, wq_4_reg, 2'b00};
    assign close_ok = {3'b000, wq_4_reg}
                      >= ({1'b0, dev2_4_reg, 2'b00} + {3'b000, s2_4_reg});

    assign sel4    = SYM_W'(it4_reg.sym);
    assign pos_cur = pos_reg[sel4];
    assign flat    = (pos_cur == '0);
    assign pos_abs = pos_cur[POS_W-1] ? (~pos_cur + 1'b1) : pos_cur;

    // Fill: add or subtract in two extra bits, then saturate to the signed range.
    assign pos_ext  = $signed({{2{pos_cur[POS_W-1]}}, pos_cur});
    assign qty_ext  = $signed({2'b00, it4_reg.qty});
    assign fill_sum = (it4_reg.side == SIDE_SELL) ? pos_ext - qty_ext : pos_ext + qty_ext;
    assign fill_top = fill_sum[POS_W+1:POS_W-1];

    always_comb
    begin
        if ((&fill_top) || !(|fill_top))
        begin
            pos_next = fill_sum[POS_W-1:0];
        end
        else if (fill_sum[POS_W+1])
        begin
            pos_next = {1'b1, {(POS_W-1){1'b0}}};
        end
        else
        begin
            pos_next = {1'b0, {(POS_W-1){1'b1}}};
        end
    end

    assign hit4 = (it4_reg.action == ACT_TICK) && it4_reg.decide
                  && (flat ? open_ok : close_ok);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SYMBOLS; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else if (fire4 && (it4_reg.action == ACT_FILL))
        begin
            pos_reg[sel4] <= pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline valids and output register
    // ------------------------------------------------------------------
    logic                 out_valid_next;
    logic                 side_next;
    logic [PRICE_W-1:0]   price_next;
    logic [QTY_W-1:0]     qty_next;
    logic                 out_side_reg;
    logic [SYM_IDX_W-1:0] out_sym_reg;
    logic [PRICE_W-1:0]   out_price_reg;
    logic [QTY_W-1:0]     out_qty_reg;

    always_comb
    begin
        if (flat)
        begin
            side_next = dir4_reg ? SIDE_SELL : SIDE_BUY;
            qty_next  = QTY_W'(1);
        end
        else
        begin
            side_next = pos_cur[POS_W-1] ? SIDE_BUY : SIDE_SELL;
            qty_next  = pos_abs;
        end
        price_next = (side_next == SIDE_SELL) ? it4_reg.bid : it4_reg.ask;
    end

    always_comb
    begin
        if (fire4 && hit4)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (go1)
            begin
                v1_reg <= keep;
            end
            if (go2)
            begin
                v2_reg <= v1_reg;
            end
            if (go3)
            begin
                v3_reg <= v2_reg;
            end
            if (go4)
            begin
                v4_reg <= v3_reg;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on advance, no reset.
    always_ff @(posedge clk)
    begin
        if (go1)
        begin
            it1_reg   <= in_item;
            m1_reg    <= in_mid;
            addr1_reg <= ram_raddr;
        end
        if (go2)
        begin
            it2_reg  <= it1_reg;
            m2_reg   <= m1_reg;
            old2_reg <= old1;
            mm2_reg  <= mm1;
            oo2_reg  <= oo1;
        end
        if (go3)
        begin
            it3_reg <= it2_reg;
            s3_reg  <= sum_next;
            q3_reg  <= sq_next;
            wm3_reg <= wm2;
        end
        if (go4)
        begin
            it4_reg    <= it3_reg;
            dev2_4_reg <= dev2_3;
            s2_4_reg   <= s2_3;
            wq_4_reg   <= wq_3;
            dir4_reg   <= dir3;
        end
        if (fire4 && hit4)
        begin
            out_side_reg  <= side_next;
            out_sym_reg   <= it4_reg.sym;
            out_price_reg <= price_next;
            out_qty_reg   <= qty_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign order_side   = out_side_reg;
    assign order_symbol = out_sym_reg;
    assign order_price  = out_price_reg;
    assign order_qty    = out_qty_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The ring is never read and written at the same slot in one cycle.
    a_ring_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_re && ram_we) |-> (ram_raddr != ram_waddr))
        else $error("ring read and write hit the same slot");

    // Input stalls only when every stage and the output register are full and blocked.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && out_valid_reg && !out_ready))
        else $error("input stalled with room in the pipeline");

    // An order never carries a zero quantity.
    a_order_qty_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_qty_reg != '0))
        else $error("order with zero quantity");

    // Symbol 0 position moves only on a fill leaving the last stage.
    a_pos_moves_on_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(pos_reg[0]) |-> $past(fire4 && (it4_reg.action == ACT_FILL)
                                       && (sel4 == '0)))
        else $error("position changed without a fill");

endmodule

// ===== rtl/core/rzse_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rzse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the rolling z-score signal engine (rolling_zscore_signal_engine).
// Depends on rzse_pkg and the engine RTL; holds its own rolling-window predictor of the orders.
module tb;
    import rzse_pkg::*;

    localparam int WIN  = DEFAULT_WINDOW;
    localparam int SYMS = DEFAULT_SYMBOLS;
    localparam int HEAD_W = $clog2(WIN);
    localparam int SUM_W = 31;
    localparam int SQ_W  = 56;
    localparam logic [PRICE_W-1:0] PRICE_TOP = '1;
    localparam longint POS_HI = 64'sd2147483647;
    localparam longint POS_LO = -64'sd2147483648;
    localparam int REPORT_LIMIT = 10;
    localparam int TAIL_CYCLES  = 16;

    typedef struct {
        side_t                side;
        logic [SYM_IDX_W-1:0] symbol;
        logic [PRICE_W-1:0]   price;
        logic [QTY_W-1:0]     qty;
    } order_t;

    // Per-symbol window state plus the queue of orders still owed by the engine.
    class signal_book;
        bit [MID_W-1:0]        mids [SYMS][WIN];
        bit [HEAD_W-1:0]       head [SYMS];
        bit [SUM_W-1:0]        sum_mid [SYMS];
        bit [SQ_W-1:0]         sq_sum [SYMS];
        bit [HEAD_W:0]         seen [SYMS];
        bit signed [POS_W-1:0] position [SYMS];
        order_t                due_orders [$];
        int unsigned           misses;

        function void note_miss(string msg);
            misses++;
            if (misses <= REPORT_LIMIT)
                $display("ERROR: %s", msg);
        endfunction

        function int pending();
            return due_orders.size();
        endfunction

        function longint held_of(int sym);
            return position[sym];
        endfunction

        // Apply one accepted item to the window state and queue the order it triggers.
        function void take_transfer(action_t act, bit [SYM_IDX_W-1:0] sym,
                                    bit [PRICE_W-1:0] bid, bit [PRICE_W-1:0] ask,
                                    side_t fside, bit [QTY_W-1:0] qty);
            bit [MID_W-1:0] mid;
            bit [MID_W-1:0] old;
            bit [127:0] s;
            bit [127:0] wm;
            bit [127:0] dev;
            bit [127:0] wq;
            longint pos;
            longint delta;
            bit fire;
            order_t ord;
            if (act == ACT_FILL) begin
                delta = qty;
                pos = position[sym];
                pos = (fside == SIDE_BUY) ? pos + delta : pos - delta;
                if (pos > POS_HI)
                    pos = POS_HI;
                else if (pos < POS_LO)
                    pos = POS_LO;
                position[sym] = pos[POS_W-1:0];
                return;
            end
            mid = MID_W'(bid) + MID_W'(ask);
            old = mids[sym][head[sym]];
            mids[sym][head[sym]] = mid;
            head[sym] = head[sym] + 1'b1;
            sum_mid[sym] = sum_mid[sym] + mid - old;
            sq_sum[sym] = sq_sum[sym] + SQ_W'(mid) * SQ_W'(mid) - SQ_W'(old) * SQ_W'(old);
            if (seen[sym] < WIN) begin
                seen[sym] = seen[sym] + 1'b1;
                if (seen[sym] < WIN)
                    return;
            end
            s = sum_mid[sym];
            wm = mid;
            wm = wm * WIN;
            wq = sq_sum[sym];
            wq = wq * WIN;
            dev = (wm >= s) ? wm - s : s - wm;
            if (position[sym] == 0)
                fire = (dev * dev + 4 * s * s) >= 4 * wq;
            else
                fire = wq >= (4 * dev * dev + s * s);
            if (!fire)
                return;
            ord.symbol = sym;
            if (position[sym] == 0) begin
                ord.side = (wm > s) ? SIDE_SELL : SIDE_BUY;
                ord.qty = 1;
            end
            else begin
                ord.side = (position[sym] > 0) ? SIDE_SELL : SIDE_BUY;
                ord.qty = (position[sym] > 0) ? position[sym] : -position[sym];
            end
            ord.price = (ord.side == SIDE_SELL) ? bid : ask;
            due_orders.push_back(ord);
        endfunction

        // Compare one accepted order against the oldest one owed.
        function void match_order(side_t side, bit [SYM_IDX_W-1:0] symbol,
                                  bit [PRICE_W-1:0] price, bit [QTY_W-1:0] qty);
            order_t want;
            if (due_orders.size() == 0) begin
                note_miss($sformatf("order with none due: side %0d sym %0d price 0x%06h qty 0x%08h",
                                    side, symbol, price, qty));
                return;
            end
            want = due_orders.pop_front();
            if (want.side != side || want.symbol != symbol || want.price != price
                || want.qty != qty)
                note_miss($sformatf({"order mismatch: expected side %0d sym %0d price 0x%06h ",
                                     "qty 0x%08h, got side %0d sym %0d price 0x%06h qty 0x%08h"},
                                    want.side, want.symbol, want.price, want.qty,
                                    side, symbol, price, qty));
        endfunction
    endclass

    signal_book book = new();

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 action = ACT_TICK;
    logic [SYM_IDX_W-1:0] symbol_index = '0;
    logic [PRICE_W-1:0]   bid_price = '0;
    logic [PRICE_W-1:0]   ask_price = '0;
    logic                 fill_side = SIDE_BUY;
    logic [QTY_W-1:0]     fill_amount = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 order_side;
    logic [SYM_IDX_W-1:0] order_symbol;
    logic [PRICE_W-1:0]   order_price;
    logic [QTY_W-1:0]     order_qty;

    // Idle switches: the sender's is used only by the stimulus process, the receiver's
    // is updated with nonblocking assignments so the output process sees a stable value.
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int stall_left = 0;
    int price_base [SYMS];

    rolling_zscore_signal_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .symbol_index (symbol_index),
        .bid_price    (bid_price),
        .ask_price    (ask_price),
        .fill_side    (fill_side),
        .fill_amount  (fill_amount),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .order_side   (order_side),
        .order_symbol (order_symbol),
        .order_price  (order_price),
        .order_qty    (order_qty)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Generous fixed limit on the run of ~1150 items, each with worst sender gap and
    // receiver stall, before declaring a hang.
    initial
    begin
        #2000000;
        $display("rolling_zscore_signal_engine regression: fail");
        $finish;
    end

    // Idle lengths: mostly short, a few long. The sender often goes back to back.
    function automatic int pick_gap(bit for_sender);
        int roll;
        roll = $urandom_range(0, 99);
        if (for_sender && roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [PRICE_W-1:0] clamp_price(int value);
        if (value < 0)
            return '0;
        if (value > PRICE_TOP)
            return PRICE_TOP;
        return value[PRICE_W-1:0];
    endfunction

    // Output side: check every order transfer, and stall ready at random while idling is on.
    // Signals read here at the edge still hold their pre-edge values.
    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_ready)
            book.match_order(side_t'(order_side), order_symbol, order_price, order_qty);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 99) < 25)
                stall_left <= pick_gap(1'b0);
        end
    end

    // Present one item and hold it until the transfer happens; leave valid high so a
    // back-to-back item never lowers and raises it in the same step.
    task automatic send_item(action_t act, logic [SYM_IDX_W-1:0] sym,
                             logic [PRICE_W-1:0] bid, logic [PRICE_W-1:0] ask,
                             side_t fside, logic [QTY_W-1:0] qty);
        int gap;
        gap = tx_idle_on ? pick_gap(1'b1) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action       <= act;
        symbol_index <= sym;
        bid_price    <= bid;
        ask_price    <= ask;
        fill_side    <= fside;
        fill_amount  <= qty;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        book.take_transfer(act, sym, bid, ask, fside, qty);
    endtask

    // Drop valid and hold off until every owed order has come out.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (book.pending() != 0);
    endtask

    // Random item: mostly ticks that hug a per-symbol base price, with spikes that push
    // the z-score past the open threshold and quiet stretches that bring it back to close.
    // Fills either flatten the position, nudge it, or slam it toward saturation.
    task automatic random_item();
        int sym;
        int roll;
        int bid;
        int ask;
        int spike;
        longint held;
        side_t fside;
        logic [QTY_W-1:0] qty;
        sym = $urandom_range(0, SYMS - 1);
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            held = book.held_of(sym);
            roll = $urandom_range(0, 99);
            if (roll < 40 && held != 0) begin
                fside = (held > 0) ? SIDE_SELL : SIDE_BUY;
                qty = (held > 0) ? held[QTY_W-1:0] : QTY_W'(-held);
            end
            else begin
                fside = side_t'($urandom_range(0, 1));
                qty = (roll < 85) ? $urandom_range(1, 3) : $urandom;
            end
            send_item(ACT_FILL, SYM_IDX_W'(sym), PRICE_W'($urandom), PRICE_W'($urandom),
                      fside, qty);
        end
        else begin
            if ($urandom_range(0, 199) == 0)
                price_base[sym] = $urandom_range(0, PRICE_TOP);
            roll = $urandom_range(0, 99);
            if (roll < 70)
                bid = price_base[sym] + $urandom_range(0, 16) - 8;
            else if (roll < 82) begin
                spike = $urandom_range(64, 4096);
                bid = $urandom_range(0, 1) ? price_base[sym] + spike : price_base[sym] - spike;
            end
            else
                bid = price_base[sym];
            ask = bid + $urandom_range(0, 3);
            if (roll >= 90) begin
                // Wild quote anywhere in the price range.
                bid = $urandom_range(0, PRICE_TOP);
                ask = $urandom_range(0, PRICE_TOP);
            end
            send_item(ACT_TICK, SYM_IDX_W'(sym), clamp_price(bid), clamp_price(ask),
                      side_t'($urandom_range(0, 1)), $urandom);
        end
    endtask

    initial
    begin
        price_base[0] = $urandom_range(0, PRICE_TOP);
        price_base[1] = PRICE_TOP - 8;
        price_base[2] = 8;
        price_base[3] = $urandom_range(0, PRICE_TOP);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with idling on both sides.
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
        // Price extremes, with the unused fill fields at their extremes too.
        send_item(ACT_TICK, 2'd0, '0, '0, SIDE_BUY, '0);
        send_item(ACT_TICK, 2'd1, PRICE_TOP, PRICE_TOP, SIDE_SELL, '1);
        send_item(ACT_TICK, 2'd2, PRICE_TOP, '0, SIDE_BUY, '1);
        send_item(ACT_TICK, 2'd3, '0, PRICE_TOP, SIDE_SELL, '0);
        // Zero-quantity fill with the unused price fields at full scale.
        send_item(ACT_FILL, 2'd0, PRICE_TOP, PRICE_TOP, SIDE_BUY, '0);
        // Drive the long position into saturation and keep pushing.
        send_item(ACT_FILL, 2'd0, '0, '0, SIDE_BUY, '1);
        send_item(ACT_FILL, 2'd0, '0, '0, SIDE_BUY, 32'd1);
        // Swing from the long limit exactly onto the short limit, then back to flat.
        send_item(ACT_FILL, 2'd0, '0, '0, SIDE_SELL, '1);
        send_item(ACT_FILL, 2'd0, '0, '0, SIDE_BUY, 32'h8000_0000);
        // Saturate short and keep pushing; this symbol later closes out 2^31.
        send_item(ACT_FILL, 2'd1, '0, '0, SIDE_SELL, '1);
        send_item(ACT_FILL, 2'd1, '0, '0, SIDE_SELL, 32'd5);
        // Open and flatten a small position.
        send_item(ACT_FILL, 2'd2, '0, '0, SIDE_BUY, 32'd7);
        send_item(ACT_FILL, 2'd2, '0, '0, SIDE_SELL, 32'd7);
        drain();

        // Back-to-back on both sides: no gaps and no output stalls.
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        repeat (300) random_item();
        drain();

        // Random gaps on both sides, with one more full pause halfway.
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
        repeat (420) random_item();
        drain();
        repeat (420) random_item();
        drain();

        // Let any stray order surface before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (book.misses == 0)
            $display("rolling_zscore_signal_engine regression: pass");
        else
            $display("rolling_zscore_signal_engine regression: fail");
        $finish;
    end
endmodule
